>>> hw/rtl/mp2d_pkg.sv
// ----------------------------------------------------------------------------
// mp2d_pkg
// Shared constants and controller/datapath command and status types for the
// streaming 2-D max pooling block.
// ----------------------------------------------------------------------------
`default_nettype none

package mp2d_pkg;

  // Default sizing of the block.
  localparam int MAX_PADDED_WIDTH_DEF = 256;
  localparam int MAX_KERNEL_DEF       = 8;
  localparam int VALUE_WIDTH_DEF      = 16;

  // Configuration register indexes.
  localparam logic [2:0] REG_KERNEL_SIZE = 3'd0;
  localparam logic [2:0] REG_STRIDE      = 3'd1;
  localparam logic [2:0] REG_PADDING     = 3'd2;
  localparam logic [2:0] REG_IN_HEIGHT   = 3'd3;
  localparam logic [2:0] REG_IN_WIDTH    = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;  // accept one input item
    logic step;  // issue one window read
    logic load;  // move the finished window into the output register
  } mp2d_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic emit;      // the offered item closes a window
    logic scan_end;  // the current read is the last of the window
    logic out_free;  // the output register can take a result
  } mp2d_sts_t;

endpackage

`default_nettype wire

>>> hw/rtl/mp2d_ctrl.sv
// ----------------------------------------------------------------------------
// mp2d_ctrl
// Sequencer: takes items, walks the window reads and hands the result to
// the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mp2d_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire mp2d_pkg::mp2d_sts_t sts,
  output mp2d_pkg::mp2d_cmd_t    cmd
);
  import mp2d_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  // Next state and command decode.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.take = 1'b1;
          if (sts.emit) state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.step = 1'b1;
        if (sts.scan_end) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/mp2d_datapath.sv
// ----------------------------------------------------------------------------
// mp2d_datapath
// Configuration registers, frame counters, line store, window maximum and
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mp2d_datapath #(
  parameter int MAX_PADDED_WIDTH = mp2d_pkg::MAX_PADDED_WIDTH_DEF,
  parameter int MAX_KERNEL       = mp2d_pkg::MAX_KERNEL_DEF,
  parameter int VALUE_WIDTH      = mp2d_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [2:0]                    cfg_index,
  input  wire logic [12:0]                   cfg_data,
  input  wire logic signed [VALUE_WIDTH-1:0] pixel_value,
  input  wire mp2d_pkg::mp2d_cmd_t           cmd,
  output mp2d_pkg::mp2d_sts_t                sts,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [VALUE_WIDTH-1:0]      max_value,
  output logic                               empty_window,
  output logic [11:0]                        out_row,
  output logic [7:0]                         out_col,
  output logic                               last_of_plane
);
  import mp2d_pkg::*;

  localparam int CW = $clog2(MAX_PADDED_WIDTH);
  localparam int SW = $clog2(MAX_KERNEL);

  // Configuration registers.
  logic [3:0]  kernel_reg;
  logic [3:0]  stride_reg;
  logic [2:0]  pad_reg;
  logic [12:0] hgt_reg;
  logic [8:0]  wid_reg;

  // Frame position state.
  logic [12:0]   frame_row;
  logic [CW-1:0] frame_col;
  logic [2:0]    row_phase;
  logic [2:0]    col_phase;
  logic [11:0]   window_row_count;
  logic [7:0]    window_col_count;
  logic [SW-1:0] row_slot;

  // Window scan state.
  logic [SW-1:0] sc_slot;
  logic [CW-1:0] sc_col;
  logic [CW-1:0] sc_cs;
  logic [3:0]    sc_i;
  logic [3:0]    sc_j;
  logic          rd_pend;
  logic [VALUE_WIDTH:0] rd_data;
  logic          any_real;
  logic signed [VALUE_WIDTH-1:0] best;
  logic [11:0]   pend_row;
  logic [7:0]    pend_col;
  logic          pend_last;

  // Line store: valid bit above the value.
  logic [VALUE_WIDTH:0] mem [MAX_KERNEL][MAX_PADDED_WIDTH];

  // Derived sizes and position decode.
  logic [4:0]  k;
  logic [3:0]  s;
  logic [12:0] h;
  logic [13:0] pd, hp, wp, wp_raw, r, cf, c, kk;
  logic        is_real, emit, last_win;
  logic [5:0]  st;
  logic [SW-1:0] start_slot;
  logic [13:0] col_start;

  always_comb begin
    if (kernel_reg == 4'd0) k = 5'd1;
    else if (kernel_reg > 4'd8) k = 5'd8;
    else k = {1'b0, kernel_reg};
    if (k > 5'(MAX_KERNEL)) k = 5'(MAX_KERNEL);
    if (stride_reg == 4'd0) s = 4'd1;
    else if (stride_reg > 4'd8) s = 4'd8;
    else s = stride_reg;
    h = (hgt_reg > 13'd4096) ? 13'd4096 : hgt_reg;
    pd = {11'd0, pad_reg};
    hp = {1'b0, h} + (pd << 1);
    if (hp == 14'd0) hp = 14'd1;
    wp_raw = {5'd0, wid_reg} + (pd << 1);
    wp = (wp_raw > 14'(MAX_PADDED_WIDTH)) ? 14'(MAX_PADDED_WIDTH) : wp_raw;
    if (wp == 14'd0) wp = 14'd1;
    r  = {1'b0, frame_row};
    cf = 14'(frame_col);
    c  = (cf >= wp) ? (wp - 14'd1) : cf;
    kk = 14'(k);
    is_real = (r >= pd) && (r < pd + {1'b0, h}) &&
              (c >= pd) && (c < pd + {5'd0, wid_reg});
    emit = (r + 14'd1 >= kk) && (row_phase == 3'd0) &&
           (c + 14'd1 >= kk) && (col_phase == 3'd0);
    last_win = (r + 14'(s) > hp - 14'd1) && (c + 14'(s) > wp - 14'd1);
    // First row slot of the window, modulo the store depth in rows.
    if (6'(row_slot) >= 6'(k - 5'd1)) st = 6'(row_slot) - 6'(k - 5'd1);
    else st = 6'(row_slot) + 6'(MAX_KERNEL) - 6'(k - 5'd1);
    start_slot = st[SW-1:0];
    col_start  = c + 14'd1 - kk;
  end

  assign sts.emit     = emit;
  assign sts.scan_end = ({1'b0, sc_i} == k - 5'd1) && ({1'b0, sc_j} == k - 5'd1);
  assign sts.out_free = !out_valid || !out_stall;

  // Line store write on take, registered read on each scan step.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      mem[row_slot][c[CW-1:0]] <= is_real ? {1'b1, pixel_value} : '0;
    end
    if (cmd.step) begin
      rd_data <= mem[sc_slot][sc_col];
    end
  end

  // Configuration and frame counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_reg       <= 4'd2;
      stride_reg       <= 4'd2;
      pad_reg          <= 3'd0;
      hgt_reg          <= 13'd32;
      wid_reg          <= 9'd32;
      frame_row        <= '0;
      frame_col        <= '0;
      row_phase        <= '0;
      col_phase        <= '0;
      window_row_count <= '0;
      window_col_count <= '0;
      row_slot         <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KERNEL_SIZE: kernel_reg <= cfg_data[3:0];
        REG_STRIDE:      stride_reg <= cfg_data[3:0];
        REG_PADDING:     pad_reg    <= cfg_data[2:0];
        REG_IN_HEIGHT:   hgt_reg    <= cfg_data[12:0];
        REG_IN_WIDTH:    wid_reg    <= cfg_data[8:0];
        default: ;
      endcase
      // Any known register write restarts the plane.
      if (cfg_index <= REG_IN_WIDTH) begin
        frame_row        <= '0;
        frame_col        <= '0;
        row_phase        <= '0;
        col_phase        <= '0;
        window_row_count <= '0;
        window_col_count <= '0;
        row_slot         <= '0;
      end
    end else if (cmd.take) begin
      // Column window grid.
      if (c + 14'd1 >= kk) begin
        if (col_phase == 3'd0) window_col_count <= window_col_count + 8'd1;
        col_phase <= ({1'b0, col_phase} + 4'd1 >= s) ? 3'd0 : col_phase + 3'd1;
      end
      if (c + 14'd1 >= wp) begin
        // End of a padded row.
        frame_col        <= '0;
        col_phase        <= '0;
        window_col_count <= '0;
        if (r + 14'd1 >= kk) begin
          if (row_phase == 3'd0) window_row_count <= window_row_count + 12'd1;
          row_phase <= ({1'b0, row_phase} + 4'd1 >= s) ? 3'd0 : row_phase + 3'd1;
        end
        if (r + 14'd1 >= hp) begin
          frame_row        <= '0;
          row_phase        <= '0;
          window_row_count <= '0;
          row_slot         <= '0;
        end else begin
          frame_row <= frame_row + 13'd1;
          row_slot  <= (row_slot == SW'(MAX_KERNEL - 1)) ? '0 : row_slot + 1'b1;
        end
      end else begin
        frame_col <= CW'(c + 14'd1);
      end
    end
  end

  // Window scan and running maximum.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= cmd.step;
    end
    if (cmd.take && emit) begin
      sc_slot   <= start_slot;
      sc_col    <= col_start[CW-1:0];
      sc_cs     <= col_start[CW-1:0];
      sc_i      <= '0;
      sc_j      <= '0;
      any_real  <= 1'b0;
      best      <= {1'b1, {(VALUE_WIDTH-1){1'b0}}};
      pend_row  <= window_row_count;
      pend_col  <= window_col_count;
      pend_last <= last_win;
    end
    if (cmd.step) begin
      if ({1'b0, sc_j} == k - 5'd1) begin
        sc_j    <= '0;
        sc_i    <= sc_i + 4'd1;
        sc_col  <= sc_cs;
        sc_slot <= (sc_slot == SW'(MAX_KERNEL - 1)) ? '0 : sc_slot + 1'b1;
      end else begin
        sc_j   <= sc_j + 4'd1;
        sc_col <= sc_col + 1'b1;
      end
    end
    if (rd_pend && rd_data[VALUE_WIDTH]) begin
      any_real <= 1'b1;
      if (!any_real || ($signed(rd_data[VALUE_WIDTH-1:0]) > best)) begin
        best <= $signed(rd_data[VALUE_WIDTH-1:0]);
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (cmd.load) begin
      max_value     <= best;
      empty_window  <= !any_real;
      out_row       <= pend_row;
      out_col       <= pend_col;
      last_of_plane <= pend_last;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/max_pool_2d_stream_top.sv
// ----------------------------------------------------------------------------
// max_pool_2d_stream_top
// Streaming 2-D max pooling over planes sent in raster order of the padded
// frame.
// ----------------------------------------------------------------------------
// Usage:
// Input items (pixel_value) arrive on in_valid/in_stall, one per position of
// the padded frame, row by row; values at padding positions are ignored.
// Each item that closes a window yields one result item on out_valid/
// out_stall: the window maximum, an empty flag, output row and column and a
// last-of-plane mark. Planes follow each other with no gap.
// An item that closes no window is taken with no stall. An item that closes
// a window stalls the input while the window is read from the single-port
// line store one entry per cycle, then the maximum goes to the output register.
// A result waiting in the output register does not block the next item; only
// the following window waits while the receiver stalls.
// Reset sets the registers to kernel 2, stride 2, padding 0, 32 by 32 and
// starts a new plane; the line store needs no clearing. A register write,
// made while the block is idle, also restarts the plane.
// ----------------------------------------------------------------------------
`default_nettype none

module max_pool_2d_stream_top #(
  parameter int MAX_PADDED_WIDTH = mp2d_pkg::MAX_PADDED_WIDTH_DEF,
  parameter int MAX_KERNEL       = mp2d_pkg::MAX_KERNEL_DEF,
  parameter int VALUE_WIDTH      = mp2d_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [2:0]                    cfg_index,
  input  wire logic [12:0]                   cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [VALUE_WIDTH-1:0] pixel_value,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [VALUE_WIDTH-1:0]      max_value,
  output logic                               empty_window,
  output logic [11:0]                        out_row,
  output logic [7:0]                         out_col,
  output logic                               last_of_plane
);
  import mp2d_pkg::*;

  mp2d_cmd_t cmd;
  mp2d_sts_t sts;

  // Sequencer.
  mp2d_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath.
  mp2d_datapath #(
    .MAX_PADDED_WIDTH (MAX_PADDED_WIDTH),
    .MAX_KERNEL       (MAX_KERNEL),
    .VALUE_WIDTH      (VALUE_WIDTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .pixel_value   (pixel_value),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .max_value     (max_value),
    .empty_window  (empty_window),
    .out_row       (out_row),
    .out_col       (out_col),
    .last_of_plane (last_of_plane)
  );

endmodule

`default_nettype wire

>>> dv/max_pool_2d_stream_top_tb.sv
// ----------------------------------------------------------------------------
// max_pool_2d_stream_top_tb
// Self-checking bench for the streaming 2-D max pooling block. A predictor in
// the bench follows the padded-frame position of every accepted pixel and
// queues the expected window results. A checker compares each result item
// field by field. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module max_pool_2d_stream_top_tb;
  import mp2d_pkg::*;

  localparam int WIDTH_CAP   = 256;
  localparam int KERNEL_CAP  = 8;
  localparam int DRAIN_WAIT  = 80;
  localparam int STALL_LIMIT = 3000;

  typedef struct {
    logic signed [15:0] max_val;
    logic               empty;
    logic [11:0]        row;
    logic [7:0]         col;
    logic               last;
  } pool_result_t;

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [2:0]         cfg_index;
  logic [12:0]        cfg_data;
  logic               in_valid;
  logic               in_stall;
  logic signed [15:0] pixel_value;
  logic               out_valid;
  logic               out_stall;
  logic signed [15:0] max_value;
  logic               empty_window;
  logic [11:0]        out_row;
  logic [7:0]         out_col;
  logic               last_of_plane;

  // Predictor state: registers, frame position and a copy of the line store.
  int unsigned        cur_kernel, cur_stride, cur_pad, cur_height, cur_width;
  int unsigned        pos_row, pos_col, row_ph, col_ph, win_rows, win_cols;
  logic [16:0]        rows_kept [KERNEL_CAP*WIDTH_CAP];
  pool_result_t       pending_windows [$];

  int                 mismatches;
  int                 quiet_cycles;
  int                 pixels_sent;
  int                 stall_left;
  bit                 send_idle_on;
  bit                 recv_idle_on;

  max_pool_2d_stream_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .pixel_value  (pixel_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .max_value    (max_value),
    .empty_window (empty_window),
    .out_row      (out_row),
    .out_col      (out_col),
    .last_of_plane(last_of_plane)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void restart_frame();
    pos_row  = 0;
    pos_col  = 0;
    row_ph   = 0;
    col_ph   = 0;
    win_rows = 0;
    win_cols = 0;
  endfunction

  // Advance the frame position by one pixel and queue a window if one closes.
  function automatic void pool_pixel(logic signed [15:0] v);
    int unsigned k, s, p, h, hp, wp, r, c, rr;
    bit real_px, emit, any;
    logic signed [15:0] best;
    logic [16:0] e;
    pool_result_t res;
    k = cur_kernel;
    s = cur_stride;
    p = cur_pad;
    h = (cur_height > 4096) ? 4096 : cur_height;
    if (k == 0) k = 1;
    if (k > KERNEL_CAP) k = KERNEL_CAP;
    if (s == 0) s = 1;
    if (s > 8) s = 8;
    hp = h + 2 * p;
    if (hp == 0) hp = 1;
    wp = cur_width + 2 * p;
    if (wp > WIDTH_CAP) wp = WIDTH_CAP;
    if (wp == 0) wp = 1;
    r = pos_row;
    c = pos_col;
    if (c >= wp) c = wp - 1;

    real_px = r >= p && r < p + h && c >= p && c < p + cur_width;
    rows_kept[(r % KERNEL_CAP) * WIDTH_CAP + c] = real_px ? {1'b1, v} : 17'd0;

    emit = r + 1 >= k && row_ph == 0 && c + 1 >= k && col_ph == 0;
    if (emit) begin
      any  = 1'b0;
      best = -16'sd32768;
      for (int i = 0; i < k; i++) begin
        rr = r + 1 - k + i;
        for (int j = 0; j < k; j++) begin
          e = rows_kept[(rr % KERNEL_CAP) * WIDTH_CAP + (c + 1 - k + j)];
          if (e[16]) begin
            if (!any || $signed(e[15:0]) > best) best = $signed(e[15:0]);
            any = 1'b1;
          end
        end
      end
      res.max_val = best;
      res.empty   = !any;
      res.row     = win_rows[11:0];
      res.col     = win_cols[7:0];
      res.last    = (r + s > hp - 1) && (c + s > wp - 1);
      pending_windows.push_back(res);
    end

    if (c + 1 >= k) begin
      if (col_ph == 0) win_cols++;
      col_ph = (col_ph + 1 >= s) ? 0 : col_ph + 1;
    end
    if (c + 1 >= wp) begin
      pos_col  = 0;
      col_ph   = 0;
      win_cols = 0;
      if (r + 1 >= k) begin
        if (row_ph == 0) win_rows++;
        row_ph = (row_ph + 1 >= s) ? 0 : row_ph + 1;
      end
      if (r + 1 >= hp) restart_frame();
      else pos_row = r + 1;
    end else begin
      pos_col = c + 1;
    end
  endfunction

  // Send one pixel after a random gap and wait until it is taken.
  task automatic send_pixel(logic signed [15:0] v);
    int gap;
    gap = send_idle_on ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    pixel_value <= v;
    do @(posedge clk); while (in_stall);
    pool_pixel(v);
    pixels_sent++;
  endtask

  // Let every queued window arrive and the block finish its last read.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_windows.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Drive one register write; the caller drops the write enable afterwards.
  task automatic write_reg(logic [2:0] idx, logic [12:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_KERNEL_SIZE: cur_kernel = data[3:0];
      REG_STRIDE:      cur_stride = data[3:0];
      REG_PADDING:     cur_pad    = data[2:0];
      REG_IN_HEIGHT:   cur_height = data[12:0];
      REG_IN_WIDTH:    cur_width  = data[8:0];
      default: ;
    endcase
    restart_frame();
  endtask

  task automatic set_shape(int k, int s, int p, int h, int w);
    wait_drained();
    write_reg(REG_KERNEL_SIZE, 13'(k));
    write_reg(REG_STRIDE, 13'(s));
    write_reg(REG_PADDING, 13'(p));
    write_reg(REG_IN_HEIGHT, 13'(h));
    write_reg(REG_IN_WIDTH, 13'(w));
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [15:0] pick_pixel();
    case ($urandom_range(0, 9))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return 16'sd0;
      default: return $signed(16'($urandom()));
    endcase
  endfunction

  // Reset values: 2x2 windows at stride 2 over a 32 by 32 plane.
  task automatic test_reset_defaults();
    for (int i = 0; i < 70; i++) send_pixel(pick_pixel());
  endtask

  // Single-pixel windows carry the extreme values straight through.
  task automatic test_extremes();
    set_shape(1, 1, 0, 2, 3);
    send_pixel(-16'sd32768);
    send_pixel(16'sd32767);
    send_pixel(16'sd0);
    send_pixel(-16'sd1);
    send_pixel(16'sd1);
    send_pixel(-16'sd32768);
  endtask

  // Wide padding around one pixel gives windows with no real pixel.
  task automatic test_padding_empty();
    set_shape(2, 2, 3, 1, 1);
    for (int i = 0; i < 49; i++) send_pixel(-16'sd32768);
  endtask

  // A kernel bigger than the padded frame closes no window.
  task automatic test_oversize_kernel();
    set_shape(8, 1, 0, 2, 2);
    for (int i = 0; i < 8; i++) send_pixel(pick_pixel());
  endtask

  // Out-of-range register values: zero and large kernel, stride, sizes.
  task automatic test_saturation();
    set_shape(0, 0, 0, 0, 0);
    for (int i = 0; i < 3; i++) send_pixel(pick_pixel());
    set_shape(15, 15, 7, 13'h1fff, 9'h1ff);
    for (int i = 0; i < 300; i++) send_pixel(pick_pixel());
    set_shape(9, 9, 7, 4097, 250);
    for (int i = 0; i < 300; i++) send_pixel(pick_pixel());
  endtask

  // Random shapes with whole planes, occasionally cut short or with raw values.
  task automatic test_random();
    int k, s, p, h, w, hp, wp, count;
    while (pixels_sent < 1700) begin
      k = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 4) : $urandom_range(1, 8);
      s = $urandom_range(1, 8);
      p = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 2) : $urandom_range(0, 7);
      h = $urandom_range(1, 12);
      w = $urandom_range(1, 16);
      hp = h + 2 * p;
      wp = w + 2 * p;
      count = hp * wp * $urandom_range(1, 2);
      if ($urandom_range(0, 9) == 0) count = $urandom_range(1, count);
      send_idle_on = $urandom_range(0, 3) != 0;
      recv_idle_on = $urandom_range(0, 3) != 0;
      if ($urandom_range(0, 15) == 0) begin
        set_shape($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 7),
                  $urandom_range(0, 8191), $urandom_range(0, 511));
        count = 120;
      end else begin
        set_shape(k, s, p, h, w);
      end
      // Keep the total close to the planned item count.
      if (pixels_sent + count > 1750) count = 1750 - pixels_sent;
      for (int i = 0; i < count; i++) send_pixel(pick_pixel());
    end
  endtask

  // Receiver stall: a random hold-off before each result item, counted while
  // the item is offered.
  always @(posedge clk) begin
    int draw;
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && !out_stall) begin
      draw = recv_idle_on ? $urandom_range(0, 8) : 0;
      stall_left <= draw;
      out_stall  <= (draw != 0);
    end else if (out_valid && stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= (stall_left > 1);
    end
  end

  task automatic flag_mismatch(string what, int exp_v, int act_v);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected %0d, got %0d", what, exp_v, act_v);
  endtask

  // Compare each result item with the oldest queued window.
  always @(posedge clk) begin
    pool_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_windows.size() == 0) begin
        flag_mismatch("unexpected result item, max_value", 0, max_value);
      end else begin
        want = pending_windows.pop_front();
        if (max_value !== want.max_val) flag_mismatch("max_value", want.max_val, max_value);
        if (empty_window !== want.empty) flag_mismatch("empty_window", want.empty, empty_window);
        if (out_row !== want.row) flag_mismatch("out_row", want.row, out_row);
        if (out_col !== want.col) flag_mismatch("out_col", want.col, out_col);
        if (last_of_plane !== want.last)
          flag_mismatch("last_of_plane", want.last, last_of_plane);
      end
    end
  end

  // Watchdog on cycles with no item moving on either channel.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_index    = REG_KERNEL_SIZE;
    cfg_data     = '0;
    in_valid     = 1'b0;
    pixel_value  = '0;
    mismatches   = 0;
    pixels_sent  = 0;
    quiet_cycles = 0;
    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;
    cur_kernel   = 2;
    cur_stride   = 2;
    cur_pad      = 0;
    cur_height   = 32;
    cur_width    = 32;
    foreach (rows_kept[i]) rows_kept[i] = '0;
    restart_frame();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_extremes();
    test_padding_empty();
    test_oversize_kernel();
    test_saturation();
    test_random();
    wait_drained();

    if (mismatches == 0 && pending_windows.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> max_pool_2d_stream_top.f
hw/rtl/mp2d_pkg.sv
hw/rtl/mp2d_ctrl.sv
hw/rtl/mp2d_datapath.sv
hw/rtl/max_pool_2d_stream_top.sv
dv/max_pool_2d_stream_top_tb.sv
